// ===== rtl/core/edfs_pkg.sv =====
// Shared constants, codes and control types of the EDF task scheduler core.
package edfs_pkg;

   localparam int MAX_TASKS   = 8;
   localparam int TIME_WIDTH  = 32;
   localparam int COUNT_WIDTH = 16;

   localparam int TASK_W      = 3;
   localparam int TASK_IDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int TCNT_W      = 4;
   localparam int FIELD_W     = 16;
   localparam int TIME_OUT_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_FIELDS_W = TIME_OUT_W + 1 + TASK_W + 1 + 1 + TASK_W + 1 + TASK_W;
   localparam int RSP_TDATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [CSR_DATA_W-1:0] FIELD_RESET = 64'h0001_0001_0001_0001;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_PERIODS_LO = 3'd0,
      CSR_PERIODS_HI = 3'd1,
      CSR_BUDGETS_LO = 3'd2,
      CSR_BUDGETS_HI = 3'd3,
      CSR_TASK_COUNT = 3'd4
   } csr_addr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_CHARGE,
      ST_COUNT,
      ST_SCAN,
      ST_DECIDE,
      ST_DONE
   } fsm_state_type;

   typedef struct packed {
      logic              accept;     // snapshot running task, clear step flags
      logic              init;       // restart: release all tasks in use at time zero
      logic              charge;     // advance time, charge running job
      logic              count;      // countdowns, miss check, retire, release
      logic              scan;       // one step of the earliest-deadline search
      logic              scan_first; // first step of the search
      logic [TASK_W-1:0] scan_idx;   // task examined by this search step
      logic              decide;     // dispatch or preempt
      logic              load_out;   // move the result into the output register
   } cmd_type;

   typedef struct packed {
      logic halted;
      logic miss;
   } status_type;

endpackage

// ===== rtl/core/edf_periodic_task_scheduler_core.sv =====
// Top level of the preemptive EDF scheduler for periodic tasks.
//
// Each request is one scheduler step: req_tdata bit 0 set restarts the task set
// at time zero and releases every task in use; clear, it advances time by one
// tick. Every request yields exactly one response that reports the time, the
// running task, dispatch and completion events and the sticky missed-deadline
// state. Periods, budgets and the task count are written on the csr_ port,
// register index in csr_addr; the user must write them only while no request
// is in progress, which the block itself does not enforce. In a tick the
// earliest-deadline search examines one task per cycle through a single
// shared comparator (one pass over all task slots), framed by charge,
// countdown and dispatch steps; a restart runs init, the search and dispatch.
// A tick that misses a deadline skips the search and dispatch; a tick while
// halted goes straight to the response and does not advance time. A new request
// can be taken as soon as the result sits in the output register; if the receiver
// stalls, a finished step waits until that register is free, and no request is taken.
// Synchronous reset returns the configuration to periods and budgets of one
// with a single task, clears all task state and time, and leaves no task
// released until the first restart request.
module edf_periodic_task_scheduler_core (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [edfs_pkg::REQ_TDATA_W-1:0]    req_tdata,  // [0] restart
   // Response channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] time_now, [32] running_valid, [35:33] running_task, [36] dispatched,
   // [37] finished_valid, [40:38] finished_task, [41] missed, [44:42] missed_task
   output logic [edfs_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // Configuration write port.
   input  logic                                csr_we,
   input  logic [edfs_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [edfs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   edfs_pkg::cmd_type    cmd;
   edfs_pkg::status_type status;

   // The sequencer steps through the phases of one request.
   edfs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_restart (req_tdata[0]),
      .req_tready  (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .status      (status),
      .cmd         (cmd)
   );

   // The datapath holds configuration, per-task state and the result register.
   edfs_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

   // A step is never overlapped with the next request.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while a step is in progress");

   // A miss step neither dispatches nor retires, and the halted state carries no events.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[41]) |-> (!rsp_tdata[36] && !rsp_tdata[37]))
      else $error("dispatch or completion reported while halted");

   // A dispatch always leaves a task on the processor.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[36]) |-> rsp_tdata[32])
      else $error("dispatch reported with no running task");

   // The missed-task index is zero whenever the miss flag is clear.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[41]) |-> (rsp_tdata[44:42] == '0))
      else $error("missed task reported without a miss");

endmodule

// ===== rtl/core/edfs_ctrl.sv =====
// Sequencer of the EDF scheduler: request handshake, step phases and result handshake.
module edfs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_restart,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  edfs_pkg::status_type status,
   output edfs_pkg::cmd_type    cmd
);

   edfs_pkg::fsm_state_type state_ff, state_in;
   logic [edfs_pkg::TASK_IDX_W-1:0] scan_ff, scan_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= edfs_pkg::ST_IDLE;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      rsp_valid_in = rsp_valid_ff;
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.scan_idx = edfs_pkg::TASK_W'(scan_ff);
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         edfs_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            scan_in    = '0;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (req_restart) begin
                  state_in = edfs_pkg::ST_INIT;
               end else if (status.halted) begin
                  state_in = edfs_pkg::ST_DONE;
               end else begin
                  state_in = edfs_pkg::ST_CHARGE;
               end
            end
         end
         edfs_pkg::ST_INIT: begin
            cmd.init = 1'b1;
            state_in = edfs_pkg::ST_SCAN;
         end
         edfs_pkg::ST_CHARGE: begin
            cmd.charge = 1'b1;
            state_in   = edfs_pkg::ST_COUNT;
         end
         edfs_pkg::ST_COUNT: begin
            cmd.count = 1'b1;
            state_in  = status.miss ? edfs_pkg::ST_DONE : edfs_pkg::ST_SCAN;
         end
         edfs_pkg::ST_SCAN: begin
            cmd.scan       = 1'b1;
            cmd.scan_first = (scan_ff == '0);
            if (scan_ff == edfs_pkg::TASK_IDX_W'(edfs_pkg::MAX_TASKS - 1)) begin
               scan_in  = '0;
               state_in = edfs_pkg::ST_DECIDE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         edfs_pkg::ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = edfs_pkg::ST_DONE;
         end
         edfs_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = edfs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = edfs_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/core/edfs_dpath.sv =====
// Datapath of the EDF scheduler: configuration, per-task state, search unit, result register.
module edfs_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [edfs_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [edfs_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  edfs_pkg::cmd_type                    cmd,
   output edfs_pkg::status_type                 status,
   output logic [edfs_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   localparam int NT = edfs_pkg::MAX_TASKS;
   localparam int CW = edfs_pkg::COUNT_WIDTH;
   localparam int TW = edfs_pkg::TASK_W;
   localparam int IW = edfs_pkg::TASK_IDX_W;
   localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

   // Configuration registers.
   logic [edfs_pkg::CSR_DATA_W-1:0] per_lo_ff, per_hi_ff, bud_lo_ff, bud_hi_ff;
   logic [edfs_pkg::TCNT_W-1:0]     task_count_ff;

   // Scheduler state.
   logic [edfs_pkg::TIME_WIDTH-1:0] tick_ff, tick_in;
   logic [CW-1:0] ttd_ff   [NT];
   logic [CW-1:0] ttd_in   [NT];
   logic [CW-1:0] units_ff [NT];
   logic [CW-1:0] units_in [NT];
   logic [NT-1:0] pend_ff, pend_in;
   logic [TW-1:0] cur_idx_ff, cur_idx_in;
   logic          cur_valid_ff, cur_valid_in;
   logic          halted_ff, halted_in;
   logic [TW-1:0] halted_task_ff, halted_task_in;

   // Per-step scratch.
   logic          was_valid_ff, was_valid_in;
   logic [TW-1:0] was_idx_ff, was_idx_in;
   logic          fin_ff, fin_in;
   logic [TW-1:0] fin_task_ff, fin_task_in;
   logic          disp_ff, disp_in;
   logic          found_ff, found_in;
   logic [TW-1:0] best_idx_ff, best_idx_in;
   logic [CW-1:0] best_ttd_ff, best_ttd_in;
   logic [CW-1:0] cur_ttd_ff, cur_ttd_in;
   logic [edfs_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Lane signals.
   logic [CW-1:0] period_w [NT];
   logic [CW-1:0] budget_w [NT];
   logic [CW-1:0] dec_w    [NT];
   logic [NT-1:0] use_w, act_w, bnd_w, lmiss_w;
   logic [edfs_pkg::TCNT_W-1:0] n_w;
   logic          miss_w;
   logic [TW-1:0] miss_task_w;

   // Charge and search helpers.
   logic [IW-1:0] cur_a, sidx_a;
   logic [CW-1:0] units_inc;
   logic          cur_out;
   logic          cand, eff_found, take;
   logic          new_valid;
   logic [TW-1:0] new_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         per_lo_ff     <= edfs_pkg::FIELD_RESET;
         per_hi_ff     <= edfs_pkg::FIELD_RESET;
         bud_lo_ff     <= edfs_pkg::FIELD_RESET;
         bud_hi_ff     <= edfs_pkg::FIELD_RESET;
         task_count_ff <= edfs_pkg::TCNT_W'(1);
      end else if (csr_we) begin
         case (edfs_pkg::csr_addr_type'(csr_addr))
            edfs_pkg::CSR_PERIODS_LO: per_lo_ff <= csr_wdata;
            edfs_pkg::CSR_PERIODS_HI: per_hi_ff <= csr_wdata;
            edfs_pkg::CSR_BUDGETS_LO: bud_lo_ff <= csr_wdata;
            edfs_pkg::CSR_BUDGETS_HI: bud_hi_ff <= csr_wdata;
            edfs_pkg::CSR_TASK_COUNT: task_count_ff <= csr_wdata[edfs_pkg::TCNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff        <= '0;
         pend_ff        <= '0;
         cur_idx_ff     <= '0;
         cur_valid_ff   <= 1'b0;
         halted_ff      <= 1'b0;
         halted_task_ff <= '0;
         was_valid_ff   <= 1'b0;
         was_idx_ff     <= '0;
         fin_ff         <= 1'b0;
         fin_task_ff    <= '0;
         disp_ff        <= 1'b0;
         found_ff       <= 1'b0;
         for (int i = 0; i < NT; i++) begin
            ttd_ff[i]   <= '0;
            units_ff[i] <= '0;
         end
      end else begin
         tick_ff        <= tick_in;
         pend_ff        <= pend_in;
         cur_idx_ff     <= cur_idx_in;
         cur_valid_ff   <= cur_valid_in;
         halted_ff      <= halted_in;
         halted_task_ff <= halted_task_in;
         was_valid_ff   <= was_valid_in;
         was_idx_ff     <= was_idx_in;
         fin_ff         <= fin_in;
         fin_task_ff    <= fin_task_in;
         disp_ff        <= disp_in;
         found_ff       <= found_in;
         for (int i = 0; i < NT; i++) begin
            ttd_ff[i]   <= ttd_in[i];
            units_ff[i] <= units_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff <= best_idx_in;
      best_ttd_ff <= best_ttd_in;
      cur_ttd_ff  <= cur_ttd_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Period and budget per task; a zero field counts as one.
   always_comb begin
      for (int i = 0; i < NT; i++) begin
         period_w[i] = (i < 4) ? per_lo_ff[(i % 4) * edfs_pkg::FIELD_W +: CW]
                               : per_hi_ff[(i % 4) * edfs_pkg::FIELD_W +: CW];
         budget_w[i] = (i < 4) ? bud_lo_ff[(i % 4) * edfs_pkg::FIELD_W +: CW]
                               : bud_hi_ff[(i % 4) * edfs_pkg::FIELD_W +: CW];
         if (period_w[i] == '0) begin
            period_w[i] = CW'(1);
         end
         if (budget_w[i] == '0) begin
            budget_w[i] = CW'(1);
         end
      end
   end

   assign n_w = (task_count_ff > edfs_pkg::TCNT_W'(NT)) ? edfs_pkg::TCNT_W'(NT) : task_count_ff;

   // Release countdown lanes and the deadline check of each task.
   always_comb begin
      miss_w      = 1'b0;
      miss_task_w = '0;
      for (int i = 0; i < NT; i++) begin
         use_w[i]   = edfs_pkg::TCNT_W'(i) < n_w;
         act_w[i]   = use_w[i] && (ttd_ff[i] != '0);
         dec_w[i]   = ttd_ff[i] - 1'b1;
         bnd_w[i]   = act_w[i] && (dec_w[i] == '0);
         lmiss_w[i] = bnd_w[i] && pend_ff[i] && (units_ff[i] < budget_w[i]);
      end
      for (int i = NT - 1; i >= 0; i--) begin
         if (lmiss_w[i]) begin
            miss_w      = 1'b1;
            miss_task_w = TW'(i);
         end
      end
   end

   assign cur_a     = cur_idx_ff[IW-1:0];
   assign sidx_a    = cmd.scan_idx[IW-1:0];
   assign units_inc = (units_ff[cur_a] == COUNT_MAX) ? COUNT_MAX : units_ff[cur_a] + 1'b1;
   assign cur_out   = cur_valid_ff && ({1'b0, cur_idx_ff} >= n_w);

   assign cand      = use_w[sidx_a] && pend_ff[sidx_a];
   assign eff_found = cmd.scan_first ? 1'b0 : found_ff;
   assign take      = found_ff && (!cur_valid_ff || (best_ttd_ff < cur_ttd_ff));
   assign new_valid = take ? 1'b1 : cur_valid_ff;
   assign new_idx   = take ? best_idx_ff : cur_idx_ff;

   always_comb begin
      tick_in        = tick_ff;
      pend_in        = pend_ff;
      cur_idx_in     = cur_idx_ff;
      cur_valid_in   = cur_valid_ff;
      halted_in      = halted_ff;
      halted_task_in = halted_task_ff;
      was_valid_in   = was_valid_ff;
      was_idx_in     = was_idx_ff;
      fin_in         = fin_ff;
      fin_task_in    = fin_task_ff;
      disp_in        = disp_ff;
      found_in       = found_ff;
      best_idx_in    = best_idx_ff;
      best_ttd_in    = best_ttd_ff;
      cur_ttd_in     = cur_ttd_ff;
      rsp_data_in    = rsp_data_ff;
      for (int i = 0; i < NT; i++) begin
         ttd_in[i]   = ttd_ff[i];
         units_in[i] = units_ff[i];
      end

      if (cmd.accept) begin
         was_valid_in = cur_valid_ff;
         was_idx_in   = cur_idx_ff;
         fin_in       = 1'b0;
         fin_task_in  = '0;
         disp_in      = 1'b0;
      end

      if (cmd.init) begin
         tick_in        = '0;
         halted_in      = 1'b0;
         halted_task_in = '0;
         cur_valid_in   = 1'b0;
         cur_idx_in     = '0;
         was_valid_in   = 1'b0;
         for (int i = 0; i < NT; i++) begin
            pend_in[i]  = use_w[i];
            units_in[i] = '0;
            ttd_in[i]   = use_w[i] ? period_w[i] : '0;
         end
      end

      if (cmd.charge) begin
         tick_in = tick_ff + 1'b1;
         if (cur_out) begin
            // A running task beyond the count leaves the processor uncharged.
            cur_valid_in = 1'b0;
         end else if (cur_valid_ff) begin
            units_in[cur_a] = units_inc;
            fin_in          = units_inc >= budget_w[cur_a];
            fin_task_in     = cur_idx_ff;
         end
      end

      if (cmd.count) begin
         for (int i = 0; i < NT; i++) begin
            if (act_w[i]) begin
               ttd_in[i] = dec_w[i];
            end
         end
         if (miss_w) begin
            halted_in      = 1'b1;
            halted_task_in = miss_task_w;
            fin_in         = 1'b0;
            fin_task_in    = '0;
         end else begin
            if (fin_ff) begin
               cur_valid_in = 1'b0;
            end
            for (int i = 0; i < NT; i++) begin
               if (fin_ff && (fin_task_ff == TW'(i))) begin
                  pend_in[i]  = 1'b0;
                  units_in[i] = '0;
               end
               if (bnd_w[i]) begin
                  pend_in[i]  = 1'b1;
                  units_in[i] = '0;
                  ttd_in[i]   = period_w[i];
               end
            end
         end
      end

      if (cmd.scan) begin
         if (cand && (!eff_found || (ttd_ff[sidx_a] < best_ttd_ff))) begin
            found_in    = 1'b1;
            best_idx_in = cmd.scan_idx;
            best_ttd_in = ttd_ff[sidx_a];
         end else begin
            found_in = eff_found;
         end
         if (cmd.scan_idx == cur_idx_ff) begin
            cur_ttd_in = ttd_ff[sidx_a];
         end
      end

      if (cmd.decide) begin
         cur_valid_in = new_valid;
         cur_idx_in   = new_idx;
         disp_in      = new_valid && (!was_valid_ff || (new_idx != was_idx_ff));
      end

      if (cmd.load_out) begin
         rsp_data_in = edfs_pkg::RSP_TDATA_W'({
            halted_ff ? halted_task_ff : TW'(0),
            halted_ff,
            fin_ff ? fin_task_ff : TW'(0),
            fin_ff,
            disp_ff,
            cur_valid_ff ? cur_idx_ff : TW'(0),
            cur_valid_ff,
            edfs_pkg::TIME_OUT_W'(tick_ff)
         });
      end
   end

   assign status.halted = halted_ff;
   assign status.miss   = miss_w;
   assign rsp_tdata     = rsp_data_ff;

endmodule
